### src/pnnd_pkg.sv
// ----------------------------------------------------------------------------
// pnnd_pkg
// shared types, constants and sizing functions for the power-of-two
// nearest-neighbor downscaler
// ----------------------------------------------------------------------------
package pnnd_pkg;

    localparam int DIM_W       = 14;   // source dimension width
    localparam int TGT_W       = 12;   // target dimension width
    localparam int ACC_W       = 26;   // accumulator width
    localparam int LOG_W       = 4;    // log2 of a target dimension
    localparam int ADDR_W      = 4;    // apb address width
    localparam int DATA_W      = 32;   // apb data width
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    localparam logic [DIM_W-1:0] MAX_SOURCE_DIM = 14'd16383;
    localparam logic [DIM_W-1:0] MIN_SOURCE_DIM = 14'd2;
    localparam logic [DIM_W-1:0] LARGE_SOURCE   = 14'd4096;

    localparam logic [LOG_W-1:0] LOG_MIN        = 4'd1;
    localparam logic [LOG_W-1:0] LOG_LARGE      = 4'd10;
    localparam logic [LOG_W-1:0] LOG_CAP_LOW    = 4'd8;
    localparam logic [LOG_W-1:0] LOG_CAP_MEDIUM = 4'd9;
    localparam int               LOG_TOP_BIT    = 11;

    localparam logic [1:0] QUALITY_LOW    = 2'd0;
    localparam logic [1:0] QUALITY_MEDIUM = 2'd1;
    localparam logic [1:0] QUALITY_HIGH   = 2'd2;

    // register indexes (byte address / 4)
    localparam logic [1:0] REG_SOURCE_WIDTH  = 2'd0;
    localparam logic [1:0] REG_SOURCE_HEIGHT = 2'd1;
    localparam logic [1:0] REG_ALPHA_PRESENT = 2'd2;
    localparam logic [1:0] REG_QUALITY_MODE  = 2'd3;

    localparam logic [DIM_W-1:0] RESET_SOURCE_WIDTH  = 14'd2;
    localparam logic [DIM_W-1:0] RESET_SOURCE_HEIGHT = 14'd2;
    localparam logic             RESET_ALPHA_PRESENT = 1'b0;
    localparam logic [1:0]       RESET_QUALITY_MODE  = QUALITY_HIGH;

    typedef struct packed {
        logic [DIM_W-1:0] source_width;
        logic [DIM_W-1:0] source_height;
        logic             alpha_present;
        logic [1:0]       quality_mode;
    } cfg_t;

    typedef struct packed {
        logic [7:0]       red;
        logic [7:0]       green;
        logic [7:0]       blue;
        logic [7:0]       alpha;
        logic             last;
        logic [TGT_W-1:0] target_width;
        logic [TGT_W-1:0] target_height;
    } pix_t;

    function automatic logic [DIM_W-1:0] clamp_size(input logic [DIM_W-1:0] s);
        logic [DIM_W-1:0] r;
        r = s;
        if (s < MIN_SOURCE_DIM)
        begin
            r = MIN_SOURCE_DIM;
        end
        else if (s > MAX_SOURCE_DIM)
        begin
            r = MAX_SOURCE_DIM;
        end
        return r;
    endfunction

    // log2 of the target size: msb position, large sources fixed, quality cap
    function automatic logic [LOG_W-1:0] target_log2(input logic [DIM_W-1:0] s,
                                                     input logic [1:0]       q);
        logic [LOG_W-1:0] lg;
        lg = LOG_MIN;
        if (s >= LARGE_SOURCE)
        begin
            lg = LOG_LARGE;
        end
        else
        begin
            for (int b = 2; b <= LOG_TOP_BIT; b++)
            begin
                if (s[b])
                begin
                    lg = LOG_W'(b);
                end
            end
        end
        case (q)
            QUALITY_LOW:
            begin
                if (lg > LOG_CAP_LOW)
                begin
                    lg = LOG_CAP_LOW;
                end
            end
            QUALITY_HIGH:
            begin
                lg = lg;
            end
            default:
            begin
                if (lg > LOG_CAP_MEDIUM)
                begin
                    lg = LOG_CAP_MEDIUM;
                end
            end
        endcase
        return lg;
    endfunction

endpackage

### src/pnnd_if.sv
// ----------------------------------------------------------------------------
// pnnd pixel channels
// valid/ready channels for source pixels and selected pixels
// ----------------------------------------------------------------------------
interface pnnd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic [7:0] alpha_in;

    modport source (output valid, output red_in, output green_in, output blue_in,
                    output alpha_in, input ready);
    modport sink   (input valid, input red_in, input green_in, input blue_in,
                    input alpha_in, output ready);
endinterface

interface pnnd_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  red_out;
    logic [7:0]  green_out;
    logic [7:0]  blue_out;
    logic [7:0]  alpha_out;
    logic        last_pixel;
    logic [11:0] target_width;
    logic [11:0] target_height;

    modport source (output valid, output red_out, output green_out, output blue_out,
                    output alpha_out, output last_pixel, output target_width,
                    output target_height, input ready);
    modport sink   (input valid, input red_out, input green_out, input blue_out,
                    input alpha_out, input last_pixel, input target_width,
                    input target_height, output ready);
endinterface

### src/pnnd_regs.sv
// ----------------------------------------------------------------------------
// pnnd_regs
// apb configuration registers; any write restarts the frame
// ----------------------------------------------------------------------------
module pnnd_regs
    import pnnd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output cfg_t              cfg,
    output logic              clear
);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       wr_en;
    logic [1:0] index;

    assign index = paddr[ADDR_W-1:2];
    assign wr_en = psel && penable && pwrite;
    assign clear = wr_en;
    assign cfg   = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (index)
                REG_SOURCE_WIDTH:  cfg_next.source_width  = pwdata[DIM_W-1:0];
                REG_SOURCE_HEIGHT: cfg_next.source_height = pwdata[DIM_W-1:0];
                REG_ALPHA_PRESENT: cfg_next.alpha_present = pwdata[0];
                REG_QUALITY_MODE:  cfg_next.quality_mode  = pwdata[1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (index)
            REG_SOURCE_WIDTH:  prdata = DATA_W'(cfg_reg.source_width);
            REG_SOURCE_HEIGHT: prdata = DATA_W'(cfg_reg.source_height);
            REG_ALPHA_PRESENT: prdata = DATA_W'(cfg_reg.alpha_present);
            REG_QUALITY_MODE:  prdata = DATA_W'(cfg_reg.quality_mode);
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.source_width  <= RESET_SOURCE_WIDTH;
            cfg_reg.source_height <= RESET_SOURCE_HEIGHT;
            cfg_reg.alpha_present <= RESET_ALPHA_PRESENT;
            cfg_reg.quality_mode  <= RESET_QUALITY_MODE;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### src/pnnd_front.sv
// ----------------------------------------------------------------------------
// pnnd_front
// takes source pixels, tracks raster position and picks the sampled ones
// ----------------------------------------------------------------------------
module pnnd_front
    import pnnd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       clear,
    pnnd_in_if.sink    pixel,
    input  logic       queue_full,
    output logic       push,
    output pix_t       push_data
);

    logic [DIM_W-1:0] src_col_reg, src_col_next;
    logic [DIM_W-1:0] src_row_reg, src_row_next;
    logic [TGT_W-1:0] dst_col_reg, dst_col_next;
    logic [TGT_W-1:0] dst_row_reg, dst_row_next;
    logic [ACC_W-1:0] cacc_reg, cacc_next;
    logic [ACC_W-1:0] racc_reg, racc_next;

    logic [DIM_W-1:0] sw;
    logic [DIM_W-1:0] sh;
    logic [LOG_W-1:0] lw;
    logic [LOG_W-1:0] lh;
    logic [TGT_W-1:0] tw;
    logic [TGT_W-1:0] th;
    logic             row_hit;
    logic             col_hit;
    logic             accept;
    logic             col_end;
    logic             row_end;

    assign sw = clamp_size(cfg.source_width);
    assign sh = clamp_size(cfg.source_height);
    assign lw = target_log2(sw, cfg.quality_mode);
    assign lh = target_log2(sh, cfg.quality_mode);
    assign tw = {{(TGT_W-1){1'b0}}, 1'b1} << lw;
    assign th = {{(TGT_W-1){1'b0}}, 1'b1} << lh;

    // source index of the next destination sample is acc >> log2(target)
    assign row_hit = (dst_row_reg < th) && (ACC_W'(src_row_reg) == (racc_reg >> lh));
    assign col_hit = (dst_col_reg < tw) && (ACC_W'(src_col_reg) == (cacc_reg >> lw));

    assign pixel.ready = !queue_full;
    assign accept      = pixel.valid && pixel.ready;
    assign push        = accept && row_hit && col_hit;

    assign col_end = ({1'b0, src_col_reg} + (DIM_W+1)'(1)) >= {1'b0, sw};
    assign row_end = ({1'b0, src_row_reg} + (DIM_W+1)'(1)) >= {1'b0, sh};

    always_comb
    begin
        push_data.red           = pixel.red_in;
        push_data.green         = pixel.green_in;
        push_data.blue          = pixel.blue_in;
        push_data.alpha         = cfg.alpha_present ? pixel.alpha_in : 8'd0;
        push_data.last          = (dst_col_reg == tw - TGT_W'(1)) &&
                                  (dst_row_reg == th - TGT_W'(1));
        push_data.target_width  = tw;
        push_data.target_height = th;
    end

    always_comb
    begin
        src_col_next = src_col_reg;
        src_row_next = src_row_reg;
        dst_col_next = dst_col_reg;
        dst_row_next = dst_row_reg;
        cacc_next    = cacc_reg;
        racc_next    = racc_reg;
        if (clear)
        begin
            src_col_next = '0;
            src_row_next = '0;
            dst_col_next = '0;
            dst_row_next = '0;
            cacc_next    = '0;
            racc_next    = '0;
        end
        else if (accept)
        begin
            if (row_hit && col_hit)
            begin
                dst_col_next = dst_col_reg + TGT_W'(1);
                cacc_next    = cacc_reg + ACC_W'(sw);
            end
            if (col_end)
            begin
                src_col_next = '0;
                dst_col_next = '0;
                cacc_next    = '0;
                if (row_end)
                begin
                    src_row_next = '0;
                    dst_row_next = '0;
                    racc_next    = '0;
                end
                else
                begin
                    if (row_hit)
                    begin
                        dst_row_next = dst_row_reg + TGT_W'(1);
                        racc_next    = racc_reg + ACC_W'(sh);
                    end
                    src_row_next = src_row_reg + DIM_W'(1);
                end
            end
            else
            begin
                src_col_next = src_col_reg + DIM_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_col_reg <= '0;
            src_row_reg <= '0;
            dst_col_reg <= '0;
            dst_row_reg <= '0;
            cacc_reg    <= '0;
            racc_reg    <= '0;
        end
        else
        begin
            src_col_reg <= src_col_next;
            src_row_reg <= src_row_next;
            dst_col_reg <= dst_col_next;
            dst_row_reg <= dst_row_next;
            cacc_reg    <= cacc_next;
            racc_reg    <= racc_next;
        end
    end

    a_src_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        src_col_reg < sw)
        else $error("source column beyond source width");

    a_dst_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        dst_col_reg <= tw)
        else $error("destination column beyond target width");

    a_dst_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        dst_row_reg <= th)
        else $error("destination row beyond target height");

endmodule

### src/pnnd_queue.sv
// ----------------------------------------------------------------------------
// pnnd_queue
// short fifo between the sampler and the result channel
// ----------------------------------------------------------------------------
module pnnd_queue
    import pnnd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  pix_t       push_data,
    output logic       full,
    pnnd_out_if.source result
);

    pix_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              pop;
    pix_t              head;

    assign full = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign pop  = result.valid && result.ready;
    assign head = mem_reg[rd_ptr_reg];

    assign result.valid         = (count_reg != '0);
    assign result.red_out       = head.red;
    assign result.green_out     = head.green;
    assign result.blue_out      = head.blue;
    assign result.alpha_out     = head.alpha;
    assign result.last_pixel    = head.last;
    assign result.target_width  = head.target_width;
    assign result.target_height = head.target_height;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("push into a full queue");

    a_fill_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == $past(count_reg) + QCNT_W'(1))
        else $error("queue fill count lost a push");

endmodule

### src/pow2_nearest_neighbor_downscale_core.sv
// ----------------------------------------------------------------------------
// pow2_nearest_neighbor_downscale_core
// nearest-neighbor downscaler of a raster pixel stream to power-of-two sizes
// ----------------------------------------------------------------------------
// result: a picked pixel accepted at a clock edge is offered on result
//   from the next cycle on (written into the fifo, head read straight out)
// throughput: one source pixel per cycle; pixel.ready drops only while the
//   four-entry result queue is full
// reset: rst_n async low; 2x2 source, no alpha, high quality, position cleared
// ----------------------------------------------------------------------------
module pow2_nearest_neighbor_downscale_core
    import pnnd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    // pixel channels
    pnnd_in_if.sink           pixel,
    pnnd_out_if.source        result
);

    cfg_t cfg;
    logic clear;
    logic push;
    pix_t push_data;
    logic queue_full;

    // no wait states on the configuration port
    assign pready = 1'b1;

    // register file; a write also restarts the frame position
    pnnd_regs u_regs (
        .clk    (clk),
        .rst_n  (rst_n),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .cfg    (cfg),
        .clear  (clear)
    );

    // front: accepts source requests while the queue is not full, walks the raster
    // position and flags the pixels that land on destination samples
    pnnd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .clear     (clear),
        .pixel     (pixel),
        .queue_full(queue_full),
        .push      (push),
        .push_data (push_data)
    );

    // back: holds picked pixels until the result side takes them
    pnnd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_data(push_data),
        .full     (queue_full),
        .result   (result)
    );

endmodule
